// ===== hw/rtl/mavg_heat_pkg.sv =====
// Shared types and constants for the moving-average heater controller.
package mavg_heat_pkg;

    // Field widths fixed by the interface.
    localparam int TEMP_W  = 9;
    localparam int POWER_W = 7;
    localparam int CFG_W   = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Reset values and limits.
    localparam logic signed [TEMP_W-1:0] RESET_TEMP     = 9'sd20;
    localparam logic [POWER_W-1:0]       POWER_MAX      = 7'd100;
    localparam logic [CFG_W-1:0]         SET_TEMP_RESET = 8'd25;
    localparam logic [CFG_W-1:0]         P_GAIN_RESET   = 8'd10;

    // Item action codes.
    typedef enum logic [0:0] {
        ACTION_SAMPLE = 1'b0,
        ACTION_UPDATE = 1'b1
    } action_t;

    // Configuration register indexes (byte address divided by four).
    typedef enum logic [0:0] {
        REG_SET_TEMP = 1'b0,
        REG_P_GAIN   = 1'b1
    } reg_idx_t;

endpackage

// ===== hw/rtl/mavg_heat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mavg_heat_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mavg_heat_lane.sv =====
// One sensor lane: sample ring, running sum and window average.
module mavg_heat_lane #(
    parameter int WINDOW = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_en,
    input  logic signed [mavg_heat_pkg::TEMP_W-1:0] sample,
    output logic signed [mavg_heat_pkg::TEMP_W-1:0] avg
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int SUM_W  = mavg_heat_pkg::TEMP_W + ADDR_W;
    // Reciprocal constants: floor(a * RECIP >> SHIFT) equals floor(a / WINDOW)
    // for every magnitude below 2**SUM_W.
    localparam int SHIFT   = SUM_W + ADDR_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam longint RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_W  = SUM_W + RECIP_W;

    logic [ADDR_W-1:0]                        ptr_reg;
    logic [ADDR_W-1:0]                        ptr_inc;
    logic [ADDR_W-1:0]                        rd_addr;
    logic [WINDOW-1:0]                        valid_reg;
    logic signed [mavg_heat_pkg::TEMP_W-1:0]  ram_rd_data;
    logic signed [mavg_heat_pkg::TEMP_W-1:0]  old_sample;
    logic signed [SUM_W-1:0]                  sum_reg;
    logic signed [SUM_W-1:0]                  sum_next;
    logic [SUM_W-1:0]                         sum_mag;
    logic [PROD_W-1:0]                        quot_prod;
    logic [mavg_heat_pkg::TEMP_W-1:0]         quot_mag;
    logic signed [mavg_heat_pkg::TEMP_W-1:0]  avg_reg;
    logic signed [mavg_heat_pkg::TEMP_W-1:0]  avg_next;

    // Pointer advance with wrap over the whole window.
    assign ptr_inc = (ptr_reg == ADDR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;

    // The read port always fetches the entry the next sample will replace.
    assign rd_addr = sample_en ? ptr_inc : ptr_reg;

    mavg_heat_ram #(
        .WIDTH (mavg_heat_pkg::TEMP_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (sample_en),
        .wr_addr (ptr_reg),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Entries never written read as the reset temperature.
    assign old_sample = valid_reg[ptr_reg] ? ram_rd_data : mavg_heat_pkg::RESET_TEMP;

    // Running sum update.
    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(old_sample);

    // Division by the window, truncating toward zero, via sign and magnitude.
    assign sum_mag   = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    assign quot_prod = PROD_W'(sum_mag) * PROD_W'(RECIP_W'(RECIP));
    assign quot_mag  = mavg_heat_pkg::TEMP_W'(quot_prod >> SHIFT);
    assign avg_next  = sum_next[SUM_W-1] ? -$signed(quot_mag) : $signed(quot_mag);

    // Ring control state, running sum and registered average.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            valid_reg <= '0;
            sum_reg   <= SUM_W'(20 * WINDOW);
            avg_reg   <= mavg_heat_pkg::RESET_TEMP;
        end
        else if (sample_en)
        begin
            ptr_reg            <= ptr_inc;
            valid_reg[ptr_reg] <= 1'b1;
            sum_reg            <= sum_next;
            avg_reg            <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

// ===== hw/rtl/mavg_heat_ctrl.sv =====
// Merge stage: proportional power from the room average, clamped to 0..100.
module mavg_heat_ctrl (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    update_en,
    input  logic signed [mavg_heat_pkg::TEMP_W-1:0] avg_room,
    input  logic [mavg_heat_pkg::CFG_W-1:0]         set_temp,
    input  logic [mavg_heat_pkg::CFG_W-1:0]         gain,
    output logic [mavg_heat_pkg::POWER_W-1:0]       power
);

    localparam int DIFF_W = mavg_heat_pkg::TEMP_W + 1;
    localparam int PROD_W = DIFF_W + mavg_heat_pkg::CFG_W + 1;

    logic signed [DIFF_W-1:0]           err;
    logic signed [PROD_W-1:0]           drive;
    logic [mavg_heat_pkg::POWER_W-1:0]  power_reg;
    logic [mavg_heat_pkg::POWER_W-1:0]  power_next;

    // Temperature error times gain.
    assign err   = $signed({2'b00, set_temp}) - $signed({avg_room[mavg_heat_pkg::TEMP_W-1],
                                                          avg_room});
    assign drive = PROD_W'(err) * $signed({{(PROD_W - mavg_heat_pkg::CFG_W){1'b0}}, gain});

    // Clamp to the drive range.
    always_comb
    begin
        if (drive < 0)
        begin
            power_next = '0;
        end
        else if (drive > $signed(PROD_W'(mavg_heat_pkg::POWER_MAX)))
        begin
            power_next = mavg_heat_pkg::POWER_MAX;
        end
        else
        begin
            power_next = drive[mavg_heat_pkg::POWER_W-1:0];
        end
    end

    // Drive level holds between updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= '0;
        end
        else if (update_en)
        begin
            power_reg <= power_next;
        end
    end

    assign power = power_reg;

endmodule

// ===== hw/rtl/moving_average_p_heater_controller.sv =====
// Top level of the moving-average proportional heater controller.
//
// The block takes one transaction per clock cycle unless out_ready stalls it;
// one result per transaction follows in the next cycle, held in the output register
// while the next transaction is taken in the same cycle the result is taken.
// Two lanes, exhaust and room, each keep a ring of WINDOW samples in a small
// RAM whose registered read port prefetches the entry the next sample will
// replace, a running sum, and a registered window average computed by a
// reciprocal multiply. A sample transaction (action 0) writes both rings and
// reports the new averages; an update transaction (action 1) recomputes power
// as (target temperature - room average) * p_gain clamped to 0..100. After
// reset every ring entry reads as 20 degrees without any clearing pass. The
// target temperature register (address 0) and p_gain (address 4) are written
// and read over the APB port and should be written only while the block is
// idle.
module moving_average_p_heater_controller #(
    parameter int WINDOW = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input channel.
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    action,
    input  logic signed [mavg_heat_pkg::TEMP_W-1:0] exhaust_temp,
    input  logic signed [mavg_heat_pkg::TEMP_W-1:0] room_temp,
    // Output channel.
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [mavg_heat_pkg::TEMP_W-1:0] avg_exhaust,
    output logic signed [mavg_heat_pkg::TEMP_W-1:0] avg_room,
    output logic [mavg_heat_pkg::POWER_W-1:0]       power,
    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [mavg_heat_pkg::APB_AW-1:0]        paddr,
    input  logic [mavg_heat_pkg::APB_DW-1:0]        pwdata,
    output logic [mavg_heat_pkg::APB_DW-1:0]        prdata,
    output logic                                    pready
);

    logic                               in_accept;
    logic                               sample_en;
    logic                               update_en;
    logic                               out_valid_reg;
    logic                               cfg_wr;
    mavg_heat_pkg::reg_idx_t            cfg_idx;
    logic [mavg_heat_pkg::CFG_W-1:0]    set_temp_reg;
    logic [mavg_heat_pkg::CFG_W-1:0]    p_gain_reg;

    // Input handshake: take a transaction whenever the result slot frees.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign sample_en = in_accept && (mavg_heat_pkg::action_t'(action) ==
                                     mavg_heat_pkg::ACTION_SAMPLE);
    assign update_en = in_accept && (mavg_heat_pkg::action_t'(action) ==
                                     mavg_heat_pkg::ACTION_UPDATE);

    // Exhaust and room lanes.
    mavg_heat_lane #(
        .WINDOW (WINDOW)
    ) u_lane_exhaust (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_en),
        .sample    (exhaust_temp),
        .avg       (avg_exhaust)
    );

    mavg_heat_lane #(
        .WINDOW (WINDOW)
    ) u_lane_room (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_en),
        .sample    (room_temp),
        .avg       (avg_room)
    );

    // Power computation from the room lane.
    mavg_heat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .update_en (update_en),
        .avg_room  (avg_room),
        .set_temp  (set_temp_reg),
        .gain      (p_gain_reg),
        .power     (power)
    );

    // Result valid flag; the lane and power registers hold the result fields,
    // which change only when a transaction is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // Configuration register writes.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = mavg_heat_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_temp_reg <= mavg_heat_pkg::SET_TEMP_RESET;
            p_gain_reg   <= mavg_heat_pkg::P_GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                mavg_heat_pkg::REG_SET_TEMP: set_temp_reg <= pwdata[mavg_heat_pkg::CFG_W-1:0];
                mavg_heat_pkg::REG_P_GAIN:   p_gain_reg   <= pwdata[mavg_heat_pkg::CFG_W-1:0];
                default:                     set_temp_reg <= set_temp_reg;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (cfg_idx)
            mavg_heat_pkg::REG_SET_TEMP: prdata = mavg_heat_pkg::APB_DW'(set_temp_reg);
            mavg_heat_pkg::REG_P_GAIN:   prdata = mavg_heat_pkg::APB_DW'(p_gain_reg);
            default:                     prdata = '0;
        endcase
    end

endmodule
